// ===== rtl/dta_pkg.sv =====
// ----------------------------------------------------------------------------
// dta_pkg
// Types, constants and calendar tables for the alarm time calculator.
// ----------------------------------------------------------------------------
package dta_pkg;

    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int DELAY_W  = 32;

    localparam int DAYS_W   = 16;
    localparam int TOD_W    = 17;
    localparam int PROD_W   = 33;
    localparam int TOTAL_W  = 34;
    localparam int REM_W    = 17;

    // floor(x / d) as (x * ceil(2^k / d)) >> k after a power-of-two pre-shift
    localparam int DAY_X_LSB    = 7;
    localparam int DAY_PROD_W   = 51;
    localparam int DAY_Q_LSB    = 35;
    localparam int HOUR_X_LSB   = 4;
    localparam int HOUR_PROD_W  = 27;
    localparam int HOUR_Q_LSB   = 21;
    localparam int MIN_REM_W    = 12;
    localparam int MIN_X_LSB    = 2;
    localparam int MIN_PROD_W   = 21;
    localparam int MIN_Q_LSB    = 14;

    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    localparam logic [TOTAL_W-1:0] LIMIT_SECS   = 34'd3155760000;
    localparam logic [PROD_W-1:0]  SECS_PER_DAY = 33'd86400;
    localparam logic [REM_W-1:0]   SECS_PER_HR  = 17'd3600;
    localparam logic [REM_W-1:0]   SECS_PER_MIN = 17'd60;
    localparam logic [YEAR_W-1:0]  LAST_YEAR    = 7'd99;
    localparam logic [YEAR_W-1:0]  CENTURY_YEAR = 7'd100;
    localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER     = 4'd12;

    typedef struct packed {
        logic [YEAR_W-1:0]   current_year_offset;
        logic [MONTH_W-1:0]  current_month;
        logic [DAY_W-1:0]    current_day;
        logic [HOUR_W-1:0]   current_hour;
        logic [MINUTE_W-1:0] current_minute;
        logic [SECOND_W-1:0] current_second;
        logic [DELAY_W-1:0]  delay_seconds;
    } dta_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   alarm_year_offset;
        logic [MONTH_W-1:0]  alarm_month;
        logic [DAY_W-1:0]    alarm_day;
        logic [HOUR_W-1:0]   alarm_hour;
        logic [MINUTE_W-1:0] alarm_minute;
        logic [SECOND_W-1:0] alarm_second;
        logic                beyond_range;
    } dta_rsp_t;

    typedef struct packed {
        logic capture;
        logic calc_days;
        logic mul;
        logic sum;
        logic day_quo;
        logic day_rem;
        logic hour_quo;
        logic hour_rem;
        logic min_quo;
        logic min_rem;
        logic year_step;
        logic month_step;
        logic load_out;
    } dta_cmd_t;

    typedef struct packed {
        logic over;
        logic year_stop;
        logic month_stop;
    } dta_sts_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'd0) && (y != CENTURY_YEAR);
    endfunction

endpackage

// ===== rtl/dta_req_if.sv =====
// ----------------------------------------------------------------------------
// dta_req_if
// Request channel: current date, time and delay.
// ----------------------------------------------------------------------------
interface dta_req_if
    import dta_pkg::*;
();
    logic     valid;
    logic     ready;
    dta_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dta_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dta_rsp_if
// Result channel: alarm date and time with range flag.
// ----------------------------------------------------------------------------
interface dta_rsp_if
    import dta_pkg::*;
();
    logic     valid;
    logic     ready;
    dta_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dta_ctrl.sv =====
// ----------------------------------------------------------------------------
// dta_ctrl
// Sequencer: steps the datapath through conversion, division and calendar
// walk, and owns both handshakes.
// ----------------------------------------------------------------------------
module dta_ctrl
    import dta_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dta_sts_t sts,
    output dta_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DAYS   = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_SUM    = 4'd3;
    localparam logic [3:0] ST_CHECK  = 4'd4;
    localparam logic [3:0] ST_DAY_Q  = 4'd5;
    localparam logic [3:0] ST_DAY_R  = 4'd6;
    localparam logic [3:0] ST_HOUR_Q = 4'd7;
    localparam logic [3:0] ST_HOUR_R = 4'd8;
    localparam logic [3:0] ST_MIN_Q  = 4'd9;
    localparam logic [3:0] ST_MIN_R  = 4'd10;
    localparam logic [3:0] ST_YEAR   = 4'd11;
    localparam logic [3:0] ST_MONTH  = 4'd12;
    localparam logic [3:0] ST_DONE   = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DAYS;
                end
            end
            ST_DAYS:
            begin
                cmd.calc_days = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.over)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DAY_Q;
                end
            end
            ST_DAY_Q:
            begin
                cmd.day_quo = 1'b1;
                state_next  = ST_DAY_R;
            end
            ST_DAY_R:
            begin
                cmd.day_rem = 1'b1;
                state_next  = ST_HOUR_Q;
            end
            ST_HOUR_Q:
            begin
                cmd.hour_quo = 1'b1;
                state_next   = ST_HOUR_R;
            end
            ST_HOUR_R:
            begin
                cmd.hour_rem = 1'b1;
                state_next   = ST_MIN_Q;
            end
            ST_MIN_Q:
            begin
                cmd.min_quo = 1'b1;
                state_next  = ST_MIN_R;
            end
            ST_MIN_R:
            begin
                cmd.min_rem = 1'b1;
                state_next  = ST_YEAR;
            end
            ST_YEAR:
            begin
                cmd.year_step = 1'b1;
                if (sts.year_stop)
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                cmd.month_step = 1'b1;
                if (sts.month_stop)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/dta_dpath.sv =====
// ----------------------------------------------------------------------------
// dta_dpath
// Datapath: date to seconds, overflow check, reciprocal-multiply dividers,
// year and month walk, result register.
// ----------------------------------------------------------------------------
module dta_dpath
    import dta_pkg::*;
(
    input  logic     clk,
    input  dta_req_t req,
    input  dta_cmd_t cmd,
    output dta_sts_t sts,
    output dta_rsp_t rsp
);

    dta_req_t              req_reg;
    logic [DAYS_W-1:0]     days_reg;
    logic [DAYS_W-1:0]     days_next;
    logic [TOD_W-1:0]      tod_reg;
    logic [TOD_W-1:0]      tod_next;
    logic [PROD_W-1:0]     prod_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [YEAR_W-1:0]     year_reg;
    logic [MONTH_W-1:0]    month_reg;
    logic                  leap_reg;
    logic [HOUR_W-1:0]     hour_reg;
    logic [MINUTE_W-1:0]   minute_reg;
    logic [SECOND_W-1:0]   second_reg;
    dta_rsp_t              rsp_reg;

    logic [MONTH_W-1:0]    mon_c;
    logic [DAY_W-1:0]      day_c;
    logic [DAY_PROD_W-1:0]  day_prod;
    logic [HOUR_PROD_W-1:0] hour_prod;
    logic [MIN_PROD_W-1:0]  min_prod;
    logic                  yr_leap;
    logic [DAYS_W-1:0]     yr_len;
    logic [DAYS_W-1:0]     mo_len;

    always_comb
    begin
        mon_c = req_reg.current_month;
        if (mon_c == '0)
        begin
            mon_c = 4'd1;
        end
        else if (mon_c > DECEMBER)
        begin
            mon_c = DECEMBER;
        end
        day_c = (req_reg.current_day == '0) ? 5'd1 : req_reg.current_day;

        days_next = 16'(16'(req_reg.current_year_offset) * 16'd365)
                  + 16'((8'(req_reg.current_year_offset) + 8'd3) >> 2)
                  - 16'(req_reg.current_year_offset > CENTURY_YEAR)
                  + 16'(days_before(mon_c))
                  + 16'(is_leap(req_reg.current_year_offset) && (mon_c > FEBRUARY))
                  + 16'(day_c) - 16'd1;

        tod_next = 17'(req_reg.current_hour) * 17'd3600
                 + 17'(req_reg.current_minute) * 17'd60
                 + 17'(req_reg.current_second);
    end

    assign day_prod  = DAY_PROD_W'(total_reg[DELAY_W-1:DAY_X_LSB])
                     * DAY_PROD_W'(DAY_RECIP);
    assign hour_prod = HOUR_PROD_W'(rem_reg[REM_W-1:HOUR_X_LSB])
                     * HOUR_PROD_W'(HOUR_RECIP);
    assign min_prod  = MIN_PROD_W'(rem_reg[MIN_REM_W-1:MIN_X_LSB])
                     * MIN_PROD_W'(MIN_RECIP);

    assign yr_leap = is_leap(year_reg);
    assign yr_len  = yr_leap ? 16'd366 : 16'd365;
    assign mo_len  = 16'(month_len(month_reg))
                   + 16'(leap_reg && (month_reg == FEBRUARY));

    assign sts.over       = total_reg >= LIMIT_SECS;
    assign sts.year_stop  = (days_reg < yr_len) || (year_reg >= LAST_YEAR);
    assign sts.month_stop = (month_reg >= DECEMBER) || (days_reg < mo_len);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.calc_days)
        begin
            days_reg <= days_next;
            tod_reg  <= tod_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(days_reg) * SECS_PER_DAY;
        end
        if (cmd.sum)
        begin
            total_reg <= TOTAL_W'(prod_reg) + TOTAL_W'(tod_reg)
                       + TOTAL_W'(req_reg.delay_seconds);
        end

        if (cmd.day_quo)
        begin
            days_reg  <= day_prod[DAY_Q_LSB+DAYS_W-1:DAY_Q_LSB];
            year_reg  <= '0;
            month_reg <= 4'd1;
        end
        if (cmd.day_rem)
        begin
            rem_reg <= total_reg[REM_W-1:0] - REM_W'(days_reg) * REM_W'(SECS_PER_DAY);
        end
        if (cmd.hour_quo)
        begin
            hour_reg <= hour_prod[HOUR_Q_LSB+HOUR_W-1:HOUR_Q_LSB];
        end
        if (cmd.hour_rem)
        begin
            rem_reg <= rem_reg - REM_W'(hour_reg) * SECS_PER_HR;
        end
        if (cmd.min_quo)
        begin
            minute_reg <= min_prod[MIN_Q_LSB+MINUTE_W-1:MIN_Q_LSB];
        end
        if (cmd.min_rem)
        begin
            second_reg <= SECOND_W'(rem_reg - REM_W'(minute_reg) * SECS_PER_MIN);
        end

        if (cmd.year_step)
        begin
            leap_reg <= yr_leap;
            if (!sts.year_stop)
            begin
                days_reg <= days_reg - yr_len;
                year_reg <= year_reg + YEAR_W'(1);
            end
        end

        if (cmd.month_step && !sts.month_stop)
        begin
            days_reg  <= days_reg - mo_len;
            month_reg <= month_reg + MONTH_W'(1);
        end

        if (cmd.load_out)
        begin
            if (sts.over)
            begin
                rsp_reg.alarm_year_offset <= '0;
                rsp_reg.alarm_month       <= '0;
                rsp_reg.alarm_day         <= '0;
                rsp_reg.alarm_hour        <= '0;
                rsp_reg.alarm_minute      <= '0;
                rsp_reg.alarm_second      <= '0;
                rsp_reg.beyond_range      <= 1'b1;
            end
            else
            begin
                rsp_reg.alarm_year_offset <= year_reg;
                rsp_reg.alarm_month       <= month_reg;
                rsp_reg.alarm_day         <= days_reg[DAY_W-1:0] + DAY_W'(1);
                rsp_reg.alarm_hour        <= hour_reg;
                rsp_reg.alarm_minute      <= minute_reg;
                rsp_reg.alarm_second      <= second_reg;
                rsp_reg.beyond_range      <= 1'b0;
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/datetime_add_seconds_unit.sv =====
// ----------------------------------------------------------------------------
// datetime_add_seconds_unit
// Alarm time calculator: date and time (years from 2000) plus a delay in
// seconds, returned as a calendar date and time with a range flag.
//
//   channel   role    contents
//   request   sink    current date, time and delay
//   alarm     source  alarm date, time and beyond_range
//
// One item at a time; request is ready only while no item is in work.
// An item whose sum is beyond 2099 goes from the overflow check straight to
// the output load; any other item passes conversion, the three reciprocal
// divisions, a walk over the years (up to 99) and the months (up to 11),
// then the output load and the return to idle.
// The result waits in an output register; a stalled alarm channel holds the
// next item in its final state until the register is free.
// Reset clears the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
module datetime_add_seconds_unit
    import dta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dta_req_if.sink   request,
    dta_rsp_if.source alarm
);

    dta_cmd_t cmd;
    dta_sts_t sts;

    dta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (alarm.valid),
        .out_ready (alarm.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dta_dpath u_dpath (
        .clk (clk),
        .req (request.data),
        .cmd (cmd),
        .sts (sts),
        .rsp (alarm.data)
    );

    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |=> !request.ready)
        else $error("request accepted while an item is in work");

    a_range_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        alarm.valid && alarm.data.beyond_range |->
            alarm.data.alarm_year_offset == '0 && alarm.data.alarm_month == '0 &&
            alarm.data.alarm_day == '0 && alarm.data.alarm_hour == '0 &&
            alarm.data.alarm_minute == '0 && alarm.data.alarm_second == '0)
        else $error("out of range result carries date fields");

    a_calendar_ok: assert property (@(posedge clk) disable iff (!rst_n)
        alarm.valid && !alarm.data.beyond_range |->
            alarm.data.alarm_month != '0 && alarm.data.alarm_month <= DECEMBER &&
            alarm.data.alarm_day != '0 && alarm.data.alarm_hour <= 5'd23 &&
            alarm.data.alarm_year_offset <= LAST_YEAR)
        else $error("calendar walk produced an impossible date");

endmodule

// ===== tb/alarm_calc_pkg.sv =====
// ----------------------------------------------------------------------------
// alarm_calc_pkg
// Calendar arithmetic that predicts the alarm date and time of a request, and
// a ledger that holds the alarms still due and checks each one that arrives.
// ----------------------------------------------------------------------------
package alarm_calc_pkg;

    import dta_pkg::*;

    localparam int unsigned     EPOCH_YEAR       = 2000;
    localparam int unsigned     COMMON_YEAR_DAYS = 365;
    localparam int unsigned     LAST_OFFSET      = 99;
    localparam int unsigned     MONTHS           = 12;
    localparam longint unsigned MINUTE_SECS      = 60;
    localparam longint unsigned HOUR_SECS        = 3600;
    localparam longint unsigned DAY_HOURS        = 24;
    localparam longint unsigned DAY_SECS         = 86400;
    localparam longint unsigned END_OF_2099      = 64'd3155760000;

    function automatic int unsigned leap_year(input int unsigned off);
        int unsigned year;
        year = EPOCH_YEAR + off;
        return (((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0)) ? 1 : 0;
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned leap);
        case (m)
            2:           return 28 + leap;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic dta_rsp_t alarm_time_of(input dta_req_t r);
        int unsigned     yoff;
        int unsigned     mon;
        int unsigned     day;
        int unsigned     y;
        int unsigned     m;
        int unsigned     leap;
        int unsigned     len;
        longint unsigned days;
        longint unsigned total;
        dta_rsp_t        a;
        yoff = r.current_year_offset;
        mon  = r.current_month;
        day  = r.current_day;
        if (mon < 1)
            mon = 1;
        if (mon > MONTHS)
            mon = MONTHS;
        if (day < 1)
            day = 1;
        days = 0;
        for (y = 0; y < yoff; y++)
            days += COMMON_YEAR_DAYS + leap_year(y);
        for (m = 1; m < mon; m++)
            days += month_days(m, leap_year(yoff));
        days += day - 1;
        total = days * DAY_SECS + 64'(r.current_hour) * HOUR_SECS
              + 64'(r.current_minute) * MINUTE_SECS + 64'(r.current_second)
              + 64'(r.delay_seconds);
        a = '0;
        if (total >= END_OF_2099)
        begin
            a.beyond_range = 1'b1;
            return a;
        end
        a.alarm_second = SECOND_W'(total % MINUTE_SECS);
        total /= MINUTE_SECS;
        a.alarm_minute = MINUTE_W'(total % MINUTE_SECS);
        total /= MINUTE_SECS;
        a.alarm_hour = HOUR_W'(total % DAY_HOURS);
        days = total / DAY_HOURS;
        y = 0;
        forever
        begin
            leap = leap_year(y);
            if (days < COMMON_YEAR_DAYS + leap || y >= LAST_OFFSET)
                break;
            days -= COMMON_YEAR_DAYS + leap;
            y++;
        end
        for (m = 1; m < MONTHS; m++)
        begin
            len = month_days(m, leap);
            if (days < len)
                break;
            days -= len;
        end
        a.alarm_year_offset = YEAR_W'(y);
        a.alarm_month       = MONTH_W'(m);
        a.alarm_day         = DAY_W'(days + 1);
        return a;
    endfunction

    class alarm_ledger;
        dta_rsp_t    due_alarms[$];
        int unsigned checked;
        int unsigned past_range;
        int unsigned failures;

        function new();
            checked    = 0;
            past_range = 0;
            failures   = 0;
        endfunction

        function int unsigned pending();
            return due_alarms.size();
        endfunction

        function void note_request(input dta_req_t r);
            due_alarms.push_back(alarm_time_of(r));
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_alarm(input dta_rsp_t got);
            dta_rsp_t want;
            checked++;
            if (due_alarms.size() == 0)
            begin
                $error("alarm item arrived with no alarm due");
                failures++;
                return;
            end
            want = due_alarms.pop_front();
            if (want.beyond_range)
                past_range++;
            compare_field("alarm_year_offset", 32'(want.alarm_year_offset),
                          32'(got.alarm_year_offset));
            compare_field("alarm_month", 32'(want.alarm_month), 32'(got.alarm_month));
            compare_field("alarm_day", 32'(want.alarm_day), 32'(got.alarm_day));
            compare_field("alarm_hour", 32'(want.alarm_hour), 32'(got.alarm_hour));
            compare_field("alarm_minute", 32'(want.alarm_minute), 32'(got.alarm_minute));
            compare_field("alarm_second", 32'(want.alarm_second), 32'(got.alarm_second));
            compare_field("beyond_range", 32'(want.beyond_range), 32'(got.beyond_range));
        endfunction
    endclass

endpackage

// ===== tb/datetime_add_seconds_unit_test.sv =====
// ----------------------------------------------------------------------------
// datetime_add_seconds_unit_test
// Drives date, time and delay requests into the alarm calculator and checks
// every alarm against a calendar prediction: directed edge cases first, then
// random dates and delays with idle bursts, a long output stall and a drain.
// ----------------------------------------------------------------------------
module datetime_add_seconds_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dta_pkg::*;
    import alarm_calc_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_ITEMS    = 1530;
    localparam int QUIET_ITEMS     = 150;
    localparam int HOLD_AT         = 400;
    localparam int DRAIN_AT        = 800;
    localparam int HOLD_CYCLES     = 600;
    localparam int TAIL_CYCLES     = 400;
    localparam int WATCHDOG_CYCLES = 5000;

    logic clk = 1'b0;
    logic rst_n;

    dta_req_if request_ch ();
    dta_rsp_if alarm_ch ();

    datetime_add_seconds_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .alarm   (alarm_ch)
    );

    alarm_ledger ledger = new();

    bit          calm;
    bit          quiet;
    bit          hold_off_pending;
    int unsigned stalled_cycles;
    int unsigned requests_sent;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic dta_req_t make_request(input int unsigned yoff, input int unsigned mon,
                                              input int unsigned day, input int unsigned hr,
                                              input int unsigned mi, input int unsigned se,
                                              input logic [DELAY_W-1:0] delay);
        dta_req_t r;
        r.current_year_offset = YEAR_W'(yoff);
        r.current_month       = MONTH_W'(mon);
        r.current_day         = DAY_W'(day);
        r.current_hour        = HOUR_W'(hr);
        r.current_minute      = MINUTE_W'(mi);
        r.current_second      = SECOND_W'(se);
        r.delay_seconds       = delay;
        return r;
    endfunction

    function automatic dta_req_t random_request();
        dta_req_t    r;
        int unsigned mode;
        int unsigned yoff;
        int unsigned mon;
        mode = $urandom_range(0, 19);
        yoff = (mode == 17) ? $urandom_range(95, 99) : $urandom_range(0, 99);
        mon  = $urandom_range(1, 12);
        r = make_request(yoff, mon, $urandom_range(1, month_days(mon, leap_year(yoff))),
                         $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                         32'd0);
        if (mode < 6)
            r.delay_seconds = $urandom_range(0, 1000000);
        else if (mode < 11)
            r.delay_seconds = $urandom_range(0, 100000000);
        else if (mode < 15)
            r.delay_seconds = $urandom_range(0, 800000000);
        else if (mode < 17)
            r.delay_seconds = $urandom;
        else if (mode == 17)
            r.delay_seconds = $urandom_range(0, 200000000);
        else if (mode == 18)
        begin
            r.delay_seconds = $urandom_range(0, 5000000);
            case ($urandom_range(0, 5))
                0:       r.current_year_offset = YEAR_W'($urandom);
                1:       r.current_month       = MONTH_W'($urandom);
                2:       r.current_day         = DAY_W'($urandom);
                3:       r.current_hour        = HOUR_W'($urandom);
                4:       r.current_minute      = MINUTE_W'($urandom);
                default: r.current_second      = SECOND_W'($urandom);
            endcase
        end
        else
            r = make_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom);
        return r;
    endfunction

    task automatic offer_request(input dta_req_t item, input bit allow_gap);
        if (allow_gap && $urandom_range(0, 3) == 0)
        begin
            request_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        request_ch.valid <= 1'b1;
        request_ch.data  <= item;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic drain_alarms();
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (request_ch.valid && request_ch.ready)
                ledger.note_request(request_ch.data);
            if (alarm_ch.valid && alarm_ch.ready)
                ledger.check_alarm(alarm_ch.data);
            if ((request_ch.valid && request_ch.ready) || (alarm_ch.valid && alarm_ch.ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_CYCLES)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        alarm_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                alarm_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                alarm_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                alarm_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        dta_req_t edge_cases[$];
        rst_n            <= 1'b0;
        request_ch.valid <= 1'b0;
        request_ch.data  <= '0;
        calm             = 1'b0;
        quiet            = 1'b0;
        hold_off_pending = 1'b0;
        stalled_cycles   = 0;
        requests_sent    = 0;

        edge_cases.push_back(make_request(0, 1, 1, 0, 0, 0, 32'd0));
        edge_cases.push_back(make_request(99, 12, 31, 23, 59, 59, 32'd0));
        edge_cases.push_back(make_request(99, 12, 31, 23, 59, 59, 32'd1));
        edge_cases.push_back(make_request(0, 1, 1, 0, 0, 0, 32'hFFFF_FFFF));
        edge_cases.push_back(make_request(0, 1, 1, 0, 0, 0, 32'd3155759999));
        edge_cases.push_back(make_request(0, 1, 1, 0, 0, 0, 32'd3155760000));
        edge_cases.push_back(make_request(100, 1, 1, 0, 0, 0, 32'd0));
        edge_cases.push_back(make_request(127, 15, 31, 31, 63, 63, 32'hFFFF_FFFF));
        edge_cases.push_back(make_request(0, 0, 0, 0, 0, 0, 32'd0));
        edge_cases.push_back(make_request(5, 15, 10, 6, 30, 15, 32'd1000));
        edge_cases.push_back(make_request(1, 2, 31, 0, 0, 0, 32'd0));
        edge_cases.push_back(make_request(3, 6, 15, 31, 63, 63, 32'd0));
        edge_cases.push_back(make_request(0, 2, 28, 0, 0, 0, 32'd86400));
        edge_cases.push_back(make_request(1, 2, 28, 0, 0, 0, 32'd86400));
        edge_cases.push_back(make_request(0, 12, 31, 23, 59, 59, 32'd1));
        edge_cases.push_back(make_request(4, 2, 29, 12, 0, 0, 32'd0));
        edge_cases.push_back(make_request(0, 1, 31, 0, 0, 0, 32'd86400));
        edge_cases.push_back(make_request(98, 12, 31, 23, 59, 59, 32'd1));
        edge_cases.push_back(make_request(99, 12, 31, 0, 0, 0, 32'd86399));
        edge_cases.push_back(make_request(99, 12, 31, 0, 0, 0, 32'd86400));
        edge_cases.push_back(make_request(50, 7, 4, 8, 30, 0, 32'h8000_0000));
        edge_cases.push_back(make_request(0, 1, 1, 0, 0, 0, 32'h8000_0000));
        edge_cases.push_back(make_request(96, 2, 29, 23, 59, 59, 32'd1));
        edge_cases.push_back(make_request(99, 0, 31, 0, 0, 0, 32'd0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (edge_cases[i])
            offer_request(edge_cases[i], 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet = (i >= RANDOM_ITEMS - QUIET_ITEMS);
            calm  = quiet || ((i / 64) % 5 == 4);
            if (i == HOLD_AT)
                hold_off_pending = 1'b1;
            if (i == DRAIN_AT)
                drain_alarms();
            offer_request(random_request(), !calm);
        end

        drain_alarms();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d alarms checked, %0d of them past the end of 2099",
                 requests_sent, ledger.checked, ledger.past_range);
        $display("calendar edges, leap days, out-of-range fields, output stall and drain run");
        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
